FILE: src/gkld_pkg.sv
// ----------------------------------------------------------------------------
// Gated KL divergence package
// Shared types, constants and command/status structs for the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package gkld_pkg;

   localparam int PROB_WIDTH     = 24;
   localparam int PROB_FRAC_BITS = 23;
   localparam int LOG_FRAC       = 24;
   localparam int LOG_WIDTH      = 29;
   localparam int SUM_WIDTH      = 40;
   localparam int COUNT_WIDTH    = 16;
   localparam int MANT_WIDTH     = 32;
   localparam int STEP_WIDTH     = 5;
   localparam int LN_WIDTH       = 29;
   localparam int TERM_WIDTH     = 53;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [PROB_WIDTH-1:0] MIN_PROB_RESET =
      PROB_WIDTH'(((64'd1 << PROB_FRAC_BITS) + 64'd50000) / 64'd100000);
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(LOG_FRAC - 1);

   typedef struct packed {
      logic [PROB_WIDTH-1:0] p_value;
      logic [PROB_WIDTH-1:0] q_value;
      logic                  last_element;
   } req_payload_type;

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] divergence_sum;
      logic [COUNT_WIDTH-1:0]      terms_used;
      logic                        saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic log_step;
      logic diff;
      logic ln_mul;
      logic term_mul;
      logic accumulate;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      logic gate_pass;
      logic last_element;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: src/gkld_datapath.sv
// ----------------------------------------------------------------------------
// Gated KL divergence datapath
// Two shared log2 square-and-compare units, ln2 scaling, term product and
// the saturating accumulator with its term counter.
// ----------------------------------------------------------------------------
`default_nettype none

module gkld_datapath import gkld_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [PROB_WIDTH-1:0] min_probability,
   input  wire req_payload_type       req_payload,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              status,
   output rsp_payload_type            rsp_payload
);

   logic [PROB_WIDTH-1:0]       p_ff, p_in;
   logic                        last_ff, last_in;
   logic                        gate_ff, gate_in;
   logic [4:0]                  ep_ff, ep_in, eq_ff, eq_in;
   logic [MANT_WIDTH-1:0]       yp_ff, yp_in, yq_ff, yq_in;
   logic [LOG_FRAC-1:0]         fp_ff, fp_in, fq_ff, fq_in;
   logic                        neg_ff, neg_in;
   logic [LOG_WIDTH-1:0]        dmag_ff, dmag_in;
   logic [LN_WIDTH-1:0]         ln_ff, ln_in;
   logic [TERM_WIDTH-1:0]       tmag_ff, tmag_in;
   logic signed [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]      count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   rsp_payload_type             out_ff, out_in;

   function automatic logic [4:0] top_bit(input logic [PROB_WIDTH-1:0] x);
      logic [4:0] e;
      e = '0;
      for (int i = 1; i < PROB_WIDTH; i++) begin
         if (x[i]) begin
            e = 5'(i);
         end
      end
      return e;
   endfunction

   function automatic logic [MANT_WIDTH+1:0] sq_step(input logic [MANT_WIDTH-1:0] y);
      logic [2*MANT_WIDTH-1:0] s;
      logic [MANT_WIDTH+1:0]   t;
      s = y * y;
      t = (MANT_WIDTH+2)'(s >> 30);
      return t;
   endfunction

   logic [MANT_WIDTH+1:0] sqp, sqq;
   logic [LOG_WIDTH-1:0]  lp, lq;
   logic signed [SUM_WIDTH+1:0] wide_sum;
   logic signed [SUM_WIDTH+1:0] sum_max, sum_min;

   always_comb begin
      p_in = p_ff; last_in = last_ff; gate_in = gate_ff;
      ep_in = ep_ff; eq_in = eq_ff; yp_in = yp_ff; yq_in = yq_ff;
      fp_in = fp_ff; fq_in = fq_ff; neg_in = neg_ff; dmag_in = dmag_ff;
      ln_in = ln_ff; tmag_in = tmag_ff; sum_in = sum_ff; count_in = count_ff;
      ovf_in = ovf_ff; out_in = out_ff;
      sqp = sq_step(yp_ff);
      sqq = sq_step(yq_ff);
      lp = {ep_ff, fp_ff};
      lq = {eq_ff, fq_ff};
      sum_max = (SUM_WIDTH+2)'(64'sd549755813887);
      sum_min = -(SUM_WIDTH+2)'(64'sd549755813888);
      wide_sum = (SUM_WIDTH+2)'(sum_ff) + (neg_ff ? -(SUM_WIDTH+2)'($signed({1'b0, tmag_ff}))
                                                  : (SUM_WIDTH+2)'($signed({1'b0, tmag_ff})));
      if (cmd.load) begin
         p_in = req_payload.p_value;
         last_in = req_payload.last_element;
         gate_in = (req_payload.p_value != '0) && (req_payload.q_value != '0) &&
                   (req_payload.p_value >= min_probability) &&
                   (req_payload.q_value >= min_probability);
         ep_in = top_bit(req_payload.p_value);
         eq_in = top_bit(req_payload.q_value);
         yp_in = MANT_WIDTH'({8'd0, req_payload.p_value} << (5'd30 - top_bit(req_payload.p_value)));
         yq_in = MANT_WIDTH'({8'd0, req_payload.q_value} << (5'd30 - top_bit(req_payload.q_value)));
         fp_in = '0;
         fq_in = '0;
      end
      if (cmd.log_step) begin
         fp_in = {fp_ff[LOG_FRAC-2:0], sqp[31]};
         fq_in = {fq_ff[LOG_FRAC-2:0], sqq[31]};
         yp_in = sqp[31] ? MANT_WIDTH'(sqp >> 1) : MANT_WIDTH'(sqp);
         yq_in = sqq[31] ? MANT_WIDTH'(sqq >> 1) : MANT_WIDTH'(sqq);
      end
      if (cmd.diff) begin
         neg_in = lp < lq;
         dmag_in = (lp < lq) ? lq - lp : lp - lq;
      end
      if (cmd.ln_mul) begin
         ln_in = LN_WIDTH'(({32'd0, 35'(dmag_ff)} * 67'(LN2_Q32) + (67'd1 << 31)) >> 32);
      end
      if (cmd.term_mul) begin
         tmag_in = TERM_WIDTH'(({29'd0, p_ff} * {24'd0, ln_ff} +
                   (53'd1 << (PROB_FRAC_BITS - 1))) >> PROB_FRAC_BITS);
      end
      if (cmd.accumulate && gate_ff) begin
         if (wide_sum > sum_max) begin
            sum_in = SUM_WIDTH'(sum_max);
            ovf_in = 1'b1;
         end else if (wide_sum < sum_min) begin
            sum_in = SUM_WIDTH'(sum_min);
            ovf_in = 1'b1;
         end else begin
            sum_in = SUM_WIDTH'(wide_sum);
         end
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.publish) begin
         out_in.divergence_sum = sum_in;
         out_in.terms_used = count_in;
         out_in.saturated = ovf_in;
         sum_in = '0;
         count_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in; last_ff <= last_in; gate_ff <= gate_in;
      ep_ff <= ep_in; eq_ff <= eq_in; yp_ff <= yp_in; yq_ff <= yq_in;
      fp_ff <= fp_in; fq_ff <= fq_in; neg_ff <= neg_in; dmag_ff <= dmag_in;
      ln_ff <= ln_in; tmag_ff <= tmag_in; out_ff <= out_in;
      if (reset) begin
         sum_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
      end
   end

   assign status.gate_pass = gate_ff;
   assign status.last_element = last_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

FILE: src/gkld_controller.sv
// ----------------------------------------------------------------------------
// Gated KL divergence controller
// Sequences load, 24 log steps, scaling, accumulation and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module gkld_controller import gkld_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOG, ST_DIFF, ST_LN, ST_TERM, ST_ACC
   } state_type;

   state_type             state_ff;
   logic [STEP_WIDTH-1:0] step_ff;
   logic                  rsp_valid_ff;
   logic                  free;

   assign free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load = req_valid && req_ready;
      cmd.log_step = (state_ff == ST_LOG);
      cmd.diff = (state_ff == ST_DIFF);
      cmd.ln_mul = (state_ff == ST_LN);
      cmd.term_mul = (state_ff == ST_TERM);
      cmd.accumulate = (state_ff == ST_ACC) && free;
      cmd.publish = cmd.accumulate && status.last_element;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_LOG;
                  step_ff <= '0;
               end
            end
            ST_LOG: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: state_ff <= ST_LN;
            ST_LN: state_ff <= ST_TERM;
            ST_TERM: state_ff <= ST_ACC;
            ST_ACC: begin
               if (free) begin
                  state_ff <= ST_IDLE;
                  if (status.last_element) begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: src/gated_kl_divergence_accumulator_core.sv
// ----------------------------------------------------------------------------
// Gated KL divergence accumulator core
// Accumulates p*ln(p/q) over gated probability pairs; emits on last element.
//
//   channel  ports              direction  content
//   request  req_valid/ready    in         p_value, q_value, last_element
//   response rsp_valid/ready    out        divergence_sum, terms_used, saturated
//   csr      csr_write_enable   in         min_probability
//
// Each pair runs from acceptance to the next ready through one load, 24
// shared square-and-compare log2 steps, then difference, ln2 multiply, term
// multiply and accumulate. Reset is synchronous and clears sum, count and flag.
// A waiting response holds the accumulate step until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_kl_divergence_accumulator_core import gkld_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_write_enable,
   input  wire logic [PROB_WIDTH-1:0] csr_write_data
);

   logic [PROB_WIDTH-1:0] min_prob_ff;
   dp_cmd_type            cmd;
   dp_status_type         status;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_prob_ff <= MIN_PROB_RESET;
      end else if (csr_write_enable) begin
         min_prob_ff <= csr_write_data;
      end
   end

   gkld_controller u_controller (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   gkld_datapath u_datapath (
      .clock, .reset, .min_probability(min_prob_ff), .req_payload,
      .cmd, .status, .rsp_payload
   );

endmodule

`default_nettype wire
